/* sv/rspe_pkg.sv */
package rspe_pkg;

	localparam int MAX_EC_DEF = 32;
	localparam int EC_W       = 6;
	localparam int COEF_W     = 5;
	localparam int BYTE_W     = 8;

	localparam logic [EC_W-1:0]   EC_RESET = 6'd10;
	// x^8 + x^4 + x^3 + x^2 + 1, x^8 term implied
	localparam logic [BYTE_W-1:0] GF_POLY  = 8'h1D;

	typedef enum logic {
		MODE_GEN = 1'b0,
		MODE_MSG = 1'b1
	} mode_t;

	// GF(256) multiply, shift-and-add with reduction; zero operand gives zero
	function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
	                                             input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] r;
		x = a;
		r = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b[k]) begin
				r = r ^ x;
			end
			x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY : '0);
		end
		return r;
	endfunction

endpackage

/* sv/rspe_if.sv */
interface rspe_in_if;
	import rspe_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [COEF_W-1:0] coef_index;
	logic [BYTE_W-1:0] data_byte;
	logic              last_symbol;

	modport source(output valid, mode, coef_index, data_byte, last_symbol, input ready);
	modport sink(input valid, mode, coef_index, data_byte, last_symbol, output ready);
endinterface

interface rspe_out_if;
	import rspe_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] parity_byte;
	logic [COEF_W-1:0] parity_index;
	logic              last_parity;

	modport source(output valid, parity_byte, parity_index, last_parity, input ready);
	modport sink(input valid, parity_byte, parity_index, last_parity, output ready);
endinterface

/* sv/rspe_datapath.sv */
module rspe_datapath #(
	parameter int  MAX_EC = rspe_pkg::MAX_EC_DEF,
	localparam int IW     = $clog2(MAX_EC),
	localparam int NW     = $clog2(MAX_EC + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [NW-1:0]             deg,
	input  logic                      free,
	rspe_in_if.sink                   in_item,
	output logic                      load,
	output logic [rspe_pkg::BYTE_W-1:0] par_nxt [MAX_EC]
);
	import rspe_pkg::*;

	logic              v_s1;
	logic              mode_s1;
	logic [COEF_W-1:0] coef_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic [BYTE_W-1:0] gen_q [MAX_EC];
	logic [BYTE_W-1:0] par_q [MAX_EC];

	logic              msg_s1;
	logic              fin_s1;
	logic              adv;
	logic [IW-1:0]     top_idx;
	logic [BYTE_W-1:0] fb;

	assign msg_s1        = (mode_s1 == MODE_MSG);
	assign fin_s1        = v_s1 && msg_s1 && last_s1;
	// a last byte waits only for the output buffer
	assign adv           = v_s1 && (!fin_s1 || free);
	assign in_item.ready = !v_s1 || adv;
	assign load          = adv && fin_s1;

	assign top_idx = IW'(deg - NW'(1));
	assign fb      = byte_s1 ^ par_q[top_idx];

	always_comb begin
		for (int i = 0; i < MAX_EC; i++) begin
			if (i < int'(deg)) begin
				par_nxt[i] = ((i == 0) ? '0 : par_q[(i == 0) ? 0 : i - 1])
				             ^ gf_mul(gen_q[i], fb);
			end else begin
				par_nxt[i] = par_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_item.ready) begin
			v_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			mode_s1 <= in_item.mode;
			coef_s1 <= in_item.coef_index;
			byte_s1 <= in_item.data_byte;
			last_s1 <= in_item.last_symbol;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !msg_s1 && (int'(coef_s1) < MAX_EC)) begin
			gen_q[IW'(coef_s1)] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_EC; i++) begin
				par_q[i] <= '0;
			end
		end else if (adv && msg_s1) begin
			for (int i = 0; i < MAX_EC; i++) begin
				par_q[i] <= last_s1 ? '0 : par_nxt[i];
			end
		end
	end

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("parity handed over while output buffer busy");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (par_q[0] == '0) && (par_q[MAX_EC-1] == '0))
		else $error("parity registers not cleared after last byte");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("stalled item lost");
`endif

endmodule

/* sv/rspe_outbuf.sv */
module rspe_outbuf #(
	parameter int  MAX_EC = rspe_pkg::MAX_EC_DEF,
	localparam int IW     = $clog2(MAX_EC),
	localparam int NW     = $clog2(MAX_EC + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [NW-1:0]               deg,
	input  logic                        load,
	input  logic [rspe_pkg::BYTE_W-1:0] par_nxt [MAX_EC],
	output logic                        free,
	rspe_out_if.source                  out_item
);
	import rspe_pkg::*;

	logic              busy_q;
	logic [IW-1:0]     e_q;
	logic [BYTE_W-1:0] sh_q [MAX_EC];
	logic              pop;
	logic              done;

	assign pop  = out_item.valid && out_item.ready;
	assign done = pop && (e_q == '0);
	// buffer can take the next remainder in the cycle its final item leaves
	assign free = !busy_q || done;

	assign out_item.valid        = busy_q;
	assign out_item.parity_byte  = sh_q[0];
	assign out_item.parity_index = COEF_W'(e_q);
	assign out_item.last_parity  = (e_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			e_q    <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			e_q    <= IW'(deg - NW'(1));
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			e_q <= e_q - IW'(1);
		end
	end

	// highest exponent goes to slot 0, then shifts down one slot per item
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < MAX_EC; k++) begin
				if (k < int'(deg)) begin
					sh_q[k] <= par_nxt[IW'(int'(deg) - 1 - k)];
				end else begin
					sh_q[k] <= '0;
				end
			end
		end else if (pop) begin
			for (int k = 0; k < MAX_EC; k++) begin
				sh_q[k] <= (k == MAX_EC - 1) ? '0 : sh_q[(k == MAX_EC - 1) ? k : k + 1];
			end
		end
	end

`ifndef SYNTH
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && (e_q == IW'($past(deg) - NW'(1)))))
		else $error("drain did not start at top exponent");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (e_q != '0)) |=> (busy_q && (e_q == $past(e_q) - IW'(1))))
		else $error("parity sequence broken");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !load) |=> !busy_q)
		else $error("items after last parity");
`endif

endmodule

/* sv/reed_solomon_parity_encoder_core.sv */
// Reed-Solomon parity encoder over GF(256), reduction polynomial 0x11D.
// Mode 0 items load generator coefficient coef_index with data_byte (the
// monic top term is implied); mode 1 items feed message bytes, highest power
// first. Each item is registered, then updates all parity registers at once,
// so one item is taken every clock unless a last byte waits for the output
// buffer. On a byte marked last_symbol the remainder moves into an output
// shift buffer and ec_count parity items follow, highest exponent first, one
// per cycle while out_item.ready is high, once the remainder has been loaded.
// Message bytes keep flowing during the drain; only the next last byte waits
// until the buffer has emptied. ec_count of 0 acts as 1 and values above
// MAX_EC act as MAX_EC. Load every coefficient below ec_count before
// encoding, and write ec_count only while the block is idle.
module reed_solomon_parity_encoder_core #(
	parameter int  MAX_EC = rspe_pkg::MAX_EC_DEF,
	localparam int NW     = $clog2(MAX_EC + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rspe_pkg::EC_W-1:0] cfg_wdata,
	rspe_in_if.sink                   in_item,
	rspe_out_if.source                out_item
);
	import rspe_pkg::*;

	logic [EC_W-1:0]   ec_q;
	logic [NW-1:0]     deg;
	logic              load;
	logic              free;
	logic [BYTE_W-1:0] par_nxt [MAX_EC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q <= EC_RESET;
		end else if (cfg_we) begin
			ec_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (ec_q == '0) begin
			deg = NW'(1);
		end else if (int'(ec_q) > MAX_EC) begin
			deg = NW'(MAX_EC);
		end else begin
			deg = NW'(ec_q);
		end
	end

	rspe_datapath #(.MAX_EC(MAX_EC)) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.deg     (deg),
		.free    (free),
		.in_item (in_item),
		.load    (load),
		.par_nxt (par_nxt)
	);

	rspe_outbuf #(.MAX_EC(MAX_EC)) u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.deg      (deg),
		.load     (load),
		.par_nxt  (par_nxt),
		.free     (free),
		.out_item (out_item)
	);

endmodule
